### src/annb_pkg.sv
// annb_pkg: shared types and constants for the Annex B NAL splitter.
// No dependencies; imported by every module of the block.
package annb_pkg;

	// Default width of the byte position counter.
	localparam int POSITION_BITS_DEF = 24;
	// Width of the reported offset and length fields.
	localparam int FIELD_W = 24;
	// Default depth of the queue between scanner and output stage.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Codec register values.
	localparam logic CODEC_H264 = 1'b0;
	localparam logic CODEC_H265 = 1'b1;

	// H.264 unit types of interest.
	localparam logic [4:0] H264_SLICE_FIRST = 5'd1;
	localparam logic [4:0] H264_IDR = 5'd5;
	localparam logic [4:0] H264_SPS = 5'd7;
	localparam logic [4:0] H264_PPS = 5'd8;

	// H.265 unit types of interest.
	localparam logic [5:0] H265_IRAP_FIRST = 6'd16;
	localparam logic [5:0] H265_IRAP_LAST = 6'd21;
	localparam logic [5:0] H265_VPS = 6'd32;
	localparam logic [5:0] H265_PPS = 6'd34;

	// One finished unit as handed from the scanner to the output stage.
	typedef struct packed {
		logic             codec;
		logic [7:0]       header;
		logic [FIELD_W-1:0] length;
		logic [FIELD_W-1:0] offset;
	} rec_t;

endpackage

### src/annb_front.sv
// annb_front: byte scanner. Finds start codes, tracks unit bounds and
// emits one record per non-empty unit. Depends on annb_pkg.
module annb_front #(
	parameter int POSITION_BITS = annb_pkg::POSITION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          codec,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output logic          rec_valid,
	output annb_pkg::rec_t rec,
	input  logic          rec_space
);
	import annb_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [POSITION_BITS-1:0] pos_q, start_q, end_q;
	logic [1:0]               zrun_q;
	logic                     inside_q, hdr_due_q;
	logic [7:0]               header_q;

	logic                     accept, start_code, byte_nz, capture, report, nonempty;
	logic [POSITION_BITS-1:0] next_pos, end_new, len;
	logic [7:0]               hdr_new;
	logic [31:0]              start_w, len_w;

	assign in_ready = rec_space;
	assign accept = in_valid && in_ready;

	assign next_pos = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign byte_nz = (in_byte != 8'd0);
	assign start_code = (in_byte == 8'd1) && (zrun_q == 2'd2);

	// Header and trimmed end as they stand after this byte (non start code path).
	assign capture = !start_code && inside_q && hdr_due_q;
	assign hdr_new = capture ? in_byte : header_q;
	assign end_new = (!start_code && inside_q && byte_nz) ? next_pos : end_q;

	assign nonempty = end_new > start_q;
	assign report = inside_q && (start_code || in_last) && nonempty;
	assign rec_valid = accept && report;

	assign len = end_new - start_q;
	assign start_w = 32'(start_q);
	assign len_w = 32'(len);

	always_comb begin
		rec.codec = codec;
		rec.header = hdr_new;
		rec.offset = start_w[FIELD_W-1:0];
		rec.length = len_w[FIELD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			start_q <= '0;
			end_q <= '0;
			zrun_q <= 2'd0;
			inside_q <= 1'b0;
			hdr_due_q <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				pos_q <= '0;
				start_q <= '0;
				end_q <= '0;
				zrun_q <= 2'd0;
				inside_q <= 1'b0;
				hdr_due_q <= 1'b0;
			end else begin
				pos_q <= next_pos;
				zrun_q <= byte_nz ? 2'd0 : ((zrun_q == 2'd2) ? 2'd2 : zrun_q + 2'd1);
				if (start_code) begin
					inside_q <= 1'b1;
					start_q <= next_pos;
					end_q <= next_pos;
					hdr_due_q <= 1'b1;
				end else begin
					end_q <= end_new;
					if (capture)
						hdr_due_q <= 1'b0;
				end
			end
		end
	end

	// Header byte holds no reset: it is always captured before it is reported.
	always_ff @(posedge clk) begin
		if (accept && capture)
			header_q <= in_byte;
	end

endmodule

### src/annb_queue.sv
// annb_queue: short FIFO of unit records between scanner and output stage.
// Depends on annb_pkg for the record type.
module annb_queue #(
	parameter int DEPTH = annb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  annb_pkg::rec_t wdata,
	output logic           not_full,
	input  logic           pop,
	output logic           not_empty,
	output annb_pkg::rec_t rdata
);
	import annb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	rec_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign not_full = (cnt_q != CNT_FULL);
	assign not_empty = (cnt_q != '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wdata;
	end

endmodule

### src/annb_back.sv
// annb_back: output stage. Decodes unit type and flags from the header byte
// per codec and holds the result beat. Depends on annb_pkg.
module annb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  annb_pkg::rec_t q_rec,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [23:0]    out_offset,
	output logic [23:0]    out_length,
	output logic [5:0]     out_type,
	output logic           out_vcl,
	output logic           out_pset,
	output logic           out_key
);
	import annb_pkg::*;

	logic       valid_q;
	logic [5:0] kind;
	logic       vcl, pset, key;
	logic [4:0] k264;
	logic [5:0] k265;

	assign q_pop = q_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_comb begin
		k264 = q_rec.header[4:0];
		k265 = q_rec.header[6:1];
		unique case (q_rec.codec)
			CODEC_H265: begin
				kind = k265;
				vcl = !k265[5];
				pset = (k265 >= H265_VPS) && (k265 <= H265_PPS);
				key = (k265 >= H265_IRAP_FIRST) && (k265 <= H265_IRAP_LAST);
			end
			default: begin
				kind = {1'b0, k264};
				vcl = (k264 >= H264_SLICE_FIRST) && (k264 <= H264_IDR);
				pset = (k264 == H264_SPS) || (k264 == H264_PPS);
				key = (k264 == H264_IDR);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_offset <= q_rec.offset;
			out_length <= q_rec.length;
			out_type <= kind;
			out_vcl <= vcl;
			out_pset <= pset;
			out_key <= key;
		end
	end

endmodule

### src/annexb_nal_splitter_unit.sv
// annexb_nal_splitter_unit: top level of the Annex B NAL unit splitter.
// Depends on annb_pkg, annb_front, annb_queue and annb_back.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ---------------------------------------------
//  s_*      in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = last_byte
//  m_*      out  m_tvalid/m_tready  m_tdata = nal_offset, nal_length
//                                   m_tuser = nal_type, is_vcl, is_param_set,
//                                             is_keyframe
//  cfg_*    in   cfg_we             cfg_wdata = codec
//
// Cycles: one byte per clock while the record queue has space; a unit record is pushed
// into the queue at the edge that takes its ending byte and then passes through the
// queue and the output register to m_*. The scanner's state update
// (position increment and the trimmed end compare) sets the one-byte-per-clock figure.
// Stalls: s_tready drops only when the record queue is full; m_tready low backs
// up the queue while the scanner keeps taking bytes until the queue is full.
// Reset: arst_n clears scanner state, queue pointers, the output valid and
// codec (H.264). A last beat returns the scanner state to reset, codec kept.
module annexb_nal_splitter_unit #(
	parameter int POSITION_BITS = annb_pkg::POSITION_BITS_DEF,
	parameter int QUEUE_DEPTH = annb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	// unit reports
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [23:0] nal_offset, [47:24] nal_length
	output logic [8:0]  m_tuser,   // [5:0] nal_type, [6] is_vcl, [7] is_param_set,
	                               // [8] is_keyframe
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_wdata  // codec: 0 H.264, 1 H.265
);
	import annb_pkg::*;

	logic codec_q;

	rec_t front_rec, queue_rec;
	logic front_valid, queue_space, queue_valid, queue_pop;

	logic [23:0] out_offset, out_length;
	logic [5:0]  out_type;
	logic        out_vcl, out_pset, out_key;

	// Codec register; the user must write it only while the block is idle, the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			codec_q <= CODEC_H264;
		else if (cfg_we)
			codec_q <= cfg_wdata;
	end

	// Front: start code search and unit bounds.
	annb_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.codec    (codec_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.rec_valid(front_valid),
		.rec      (front_rec),
		.rec_space(queue_space)
	);

	// Queue decouples scanner from the output handshake.
	annb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_valid),
		.wdata    (front_rec),
		.not_full (queue_space),
		.pop      (queue_pop),
		.not_empty(queue_valid),
		.rdata    (queue_rec)
	);

	// Back: type decode and the registered output beat.
	annb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (queue_valid),
		.q_rec     (queue_rec),
		.q_pop     (queue_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_offset(out_offset),
		.out_length(out_length),
		.out_type  (out_type),
		.out_vcl   (out_vcl),
		.out_pset  (out_pset),
		.out_key   (out_key)
	);

	assign m_tdata = {out_length, out_offset};
	assign m_tuser = {out_key, out_pset, out_vcl, out_type};

endmodule
